// ----- hw/rtl/fpd_pkg.sv -----
// Flight phase detector: shared widths, codes, transaction structs and the
// camera pulse lookup. No dependencies; every other file imports this one.
`timescale 1ns / 1ps
`default_nettype none

package fpd_pkg;

   localparam int WINDOW_LEN_DEF = 60;
   localparam int CHECK_PERIOD_S = 1;
   localparam int ALT_HYSTERESIS = 750;

   // field widths
   localparam int CMD_W    = 2;
   localparam int ALT_W    = 18;
   localparam int PRESS_W  = 17;
   localparam int PHASE_W  = 3;
   localparam int DIR_W    = 2;
   localparam int PULSE_W  = 10;

   // configuration
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int GND_W      = 14;
   localparam int TROP_W     = 15;
   localparam int LAND_W     = 17;
   localparam int RISE_W     = 11;
   localparam int SINK_W     = 12;

   // the window sum telescopes to the difference of two samples, so it stays
   // within one bit more than a single delta
   localparam int ADELTA_W = ALT_W + 1;
   localparam int PDELTA_W = PRESS_W + 1;
   localparam int ASUM_W   = ADELTA_W + 1;
   localparam int PSUM_W   = PDELTA_W + 1;
   localparam int CMP_W    = 32;
   localparam int THR_W    = 20;

   localparam logic signed [CMP_W-1:0] M_TO_CM   = CMP_W'(100);
   localparam logic signed [CMP_W-1:0] PA_TO_CM  = CMP_W'(-9);
   localparam logic signed [CMP_W-1:0] CMP_ZERO  = CMP_W'(0);
   localparam logic signed [THR_W-1:0] HYST      = THR_W'(ALT_HYSTERESIS);

   localparam logic [GND_W-1:0]         GND_RST  = GND_W'(1500);
   localparam logic [TROP_W-1:0]        TROP_RST = TROP_W'(12500);
   localparam logic [LAND_W-1:0]        LAND_RST = LAND_W'(3600);
   localparam logic [RISE_W-1:0]        RISE_RST = RISE_W'(200);
   localparam logic signed [SINK_W-1:0] SINK_RST = SINK_W'(-200);

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_FORCE   = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GROUND    = 3'd0,
      CSR_TROP      = 3'd1,
      CSR_LANDING   = 3'd2,
      CSR_RISE      = 3'd3,
      CSR_SINK      = 3'd4,
      CSR_TEST_MODE = 3'd5
   } csr_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_NOFIX       = 3'd0,
      PH_GROUND      = 3'd1,
      PH_TAKEOFF     = 3'd2,
      PH_STRATO_UP   = 3'd3,
      PH_STRATO_FALL = 3'd4,
      PH_FALLING     = 3'd5,
      PH_LANDING     = 3'd6,
      PH_HOVER       = 3'd7
   } phase_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_HOVER = 2'd0,
      DIR_UP    = 2'd1,
      DIR_DOWN  = 2'd2
   } dir_type;

   typedef struct packed {
      logic sample;
      logic clear;
      logic force_phase;
   } op_type;

   typedef struct packed {
      logic [GND_W-1:0]         ground;
      logic [TROP_W-1:0]        trop;
      logic [LAND_W-1:0]        land;
      logic [RISE_W-1:0]        rise;
      logic signed [SINK_W-1:0] sink;
   } cfg_type;

   typedef struct packed {
      op_type                   op;
      phase_type                forced;
      logic                     full;
      logic signed [ALT_W-1:0]  alt;
      logic signed [ASUM_W-1:0] asum;
      logic signed [PSUM_W-1:0] psum;
   } win_type;

   typedef struct packed {
      logic lt_gnd;
      logic lt_trop;
      logic lt_trop_lo;
      logic lt_trop_hi;
      logic lt_land;
      logic lt_land_hi;
   } alt_flags_type;

   typedef struct packed {
      op_type        op;
      phase_type     forced;
      logic          full;
      logic          rise_hit;
      logic          rise_pos;
      logic          sink_hit;
      logic          sink_neg;
      alt_flags_type flags;
   } cmp_type;

   function automatic logic [PULSE_W-1:0] pulse_ms(phase_type ph);
      logic [PULSE_W-1:0] ms;
      case (ph)
         PH_STRATO_UP:   ms = PULSE_W'(100);
         PH_STRATO_FALL: ms = PULSE_W'(300);
         PH_FALLING:     ms = PULSE_W'(500);
         PH_LANDING:     ms = PULSE_W'(800);
         default:        ms = '0;
      endcase
      return ms;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fpd_if.sv -----
// Flight phase detector: sample and result channels (valid/ready + payload).
// Depends on fpd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fpd_req_if;
   import fpd_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic                    gps_fix;
   logic signed [ALT_W-1:0] altitude_m;
   logic [PRESS_W-1:0]      pressure_pa;
   logic [PHASE_W-1:0]      forced_phase;

   modport source (output valid, command, gps_fix, altitude_m, pressure_pa, forced_phase,
                   input ready);
   modport sink   (input valid, command, gps_fix, altitude_m, pressure_pa, forced_phase,
                   output ready);
endinterface

interface fpd_rsp_if;
   import fpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic [DIR_W-1:0]   direction;
   logic               phase_changed;
   logic               landing_trigger;
   logic               window_full;
   logic [PULSE_W-1:0] camera_pulse_ms;

   modport source (output valid, phase, direction, phase_changed, landing_trigger,
                   window_full, camera_pulse_ms, input ready);
   modport sink   (input valid, phase, direction, phase_changed, landing_trigger,
                   window_full, camera_pulse_ms, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/fpd_window.sv -----
// Flight phase detector: delta rings in two synchronous memories and the
// running window sums (read at accept, modify and write back on leaving).
// Depends on fpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpd_window #(
   parameter int WINDOW_LEN = fpd_pkg::WINDOW_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  fpd_pkg::op_type                 in_op,
   input  logic signed [fpd_pkg::ALT_W-1:0] in_alt,
   input  logic [fpd_pkg::PRESS_W-1:0]     in_press,
   input  fpd_pkg::phase_type              in_forced,
   output logic                            out_valid,
   input  logic                            out_ready,
   output fpd_pkg::win_type                out_data
);
   import fpd_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_LEN);
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
   localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW_LEN);

   logic signed [ADELTA_W-1:0] alt_ring_mem   [WINDOW_LEN];
   logic signed [PDELTA_W-1:0] press_ring_mem [WINDOW_LEN];

   logic [SLOT_W-1:0]          rd_slot_ff, rd_slot_in;
   logic                       p1_valid_ff, p1_valid_in;
   op_type                     p1_op_ff;
   logic signed [ALT_W-1:0]    p1_alt_ff;
   logic [PRESS_W-1:0]         p1_press_ff;
   phase_type                  p1_forced_ff;
   logic [SLOT_W-1:0]          p1_slot_ff;
   logic signed [ADELTA_W-1:0] alt_old_ff;
   logic signed [PDELTA_W-1:0] press_old_ff;

   logic signed [ALT_W-1:0]    last_alt_ff, last_alt_in;
   logic [PRESS_W-1:0]         last_press_ff, last_press_in;
   logic signed [ASUM_W-1:0]   asum_ff, asum_in, asum_new;
   logic signed [PSUM_W-1:0]   psum_ff, psum_in, psum_new;
   logic [FILL_W-1:0]          fill_ff, fill_in, fill_new;

   logic                       accept;
   logic                       fire;
   logic                       first;
   logic                       full_before;
   logic signed [ADELTA_W-1:0] alt_step;
   logic signed [PDELTA_W-1:0] press_step;
   logic signed [ASUM_W-1:0]   alt_drop;
   logic signed [PSUM_W-1:0]   press_drop;

   assign in_ready = !p1_valid_ff || out_ready;
   assign accept   = in_valid && in_ready;
   assign fire     = p1_valid_ff && out_ready;

   // read pointer runs at accept time; each sample owns the slot it read
   always_comb begin
      rd_slot_in = rd_slot_ff;
      if (clear) begin
         rd_slot_in = '0;
      end else if (accept) begin
         if (in_op.clear) begin
            rd_slot_in = '0;
         end else if (in_op.sample) begin
            rd_slot_in = (rd_slot_ff == SLOT_LAST) ? '0 : rd_slot_ff + 1'b1;
         end
      end
   end

   assign p1_valid_in = in_ready ? in_valid : p1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_slot_ff  <= '0;
         p1_valid_ff <= 1'b0;
      end else begin
         rd_slot_ff  <= rd_slot_in;
         p1_valid_ff <= p1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p1_op_ff     <= in_op;
         p1_alt_ff    <= in_alt;
         p1_press_ff  <= in_press;
         p1_forced_ff <= in_forced;
         p1_slot_ff   <= rd_slot_ff;
      end
   end

   // ring memories: registered read at accept, write back when the item leaves
   always_ff @(posedge clock) begin
      if (accept) begin
         alt_old_ff   <= alt_ring_mem[rd_slot_ff];
         press_old_ff <= press_ring_mem[rd_slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (fire && p1_op_ff.sample) begin
         alt_ring_mem[p1_slot_ff]   <= alt_step;
         press_ring_mem[p1_slot_ff] <= press_step;
      end
   end

   assign first       = (fill_ff == '0);
   assign full_before = (fill_ff == FILL_MAX);

   always_comb begin
      alt_step   = first ? '0 : ADELTA_W'(p1_alt_ff) - ADELTA_W'(last_alt_ff);
      press_step = first ? '0 : PDELTA_W'(p1_press_ff) - PDELTA_W'(last_press_ff);
      alt_drop   = full_before ? ASUM_W'(alt_old_ff) : '0;
      press_drop = full_before ? PSUM_W'(press_old_ff) : '0;
   end

   always_comb begin
      asum_new = asum_ff;
      psum_new = psum_ff;
      fill_new = fill_ff;
      if (p1_op_ff.clear) begin
         asum_new = '0;
         psum_new = '0;
         fill_new = '0;
      end else if (p1_op_ff.sample) begin
         asum_new = asum_ff + ASUM_W'(alt_step) - alt_drop;
         psum_new = psum_ff + PSUM_W'(press_step) - press_drop;
         fill_new = full_before ? fill_ff : fill_ff + 1'b1;
      end
   end

   always_comb begin
      asum_in       = asum_ff;
      psum_in       = psum_ff;
      fill_in       = fill_ff;
      last_alt_in   = last_alt_ff;
      last_press_in = last_press_ff;
      if (clear) begin
         asum_in = '0;
         psum_in = '0;
         fill_in = '0;
      end else if (fire) begin
         asum_in = asum_new;
         psum_in = psum_new;
         fill_in = fill_new;
         if (p1_op_ff.sample) begin
            last_alt_in   = p1_alt_ff;
            last_press_in = p1_press_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asum_ff       <= '0;
         psum_ff       <= '0;
         fill_ff       <= '0;
         last_alt_ff   <= '0;
         last_press_ff <= '0;
      end else begin
         asum_ff       <= asum_in;
         psum_ff       <= psum_in;
         fill_ff       <= fill_in;
         last_alt_ff   <= last_alt_in;
         last_press_ff <= last_press_in;
      end
   end

   assign out_valid = p1_valid_ff;

   always_comb begin
      out_data.op     = p1_op_ff;
      out_data.forced = p1_forced_ff;
      out_data.full   = (fill_new == FILL_MAX);
      out_data.alt    = p1_alt_ff;
      out_data.asum   = asum_new;
      out_data.psum   = psum_new;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fpd_rate.sv -----
// Flight phase detector: vertical rate scaling and threshold compares over two
// pipeline stages (scale and threshold products, then compares).
// Depends on fpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpd_rate #(
   parameter int WINDOW_LEN = fpd_pkg::WINDOW_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  fpd_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  fpd_pkg::win_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output fpd_pkg::cmp_type  out_data
);
   import fpd_pkg::*;

   localparam logic signed [CMP_W-1:0] SPAN = CMP_W'(WINDOW_LEN * CHECK_PERIOD_S);

   logic                    p2_valid_ff, p2_valid_in;
   win_type                 p2_ff;
   logic                    p3_valid_ff, p3_valid_in;
   op_type                  p3_op_ff;
   phase_type               p3_forced_ff;
   logic                    p3_full_ff;
   logic signed [CMP_W-1:0] p3_rate_ff;
   logic signed [CMP_W-1:0] p3_up_thr_ff;
   logic signed [CMP_W-1:0] p3_dn_thr_ff;
   alt_flags_type           p3_flags_ff;

   logic                    p3_load;
   logic                    p2_move;
   logic signed [THR_W-1:0] alt_x;
   logic signed [THR_W-1:0] gnd_x;
   logic signed [THR_W-1:0] trop_x;
   logic signed [THR_W-1:0] land_x;
   logic signed [CMP_W-1:0] rate;
   logic signed [CMP_W-1:0] up_thr;
   logic signed [CMP_W-1:0] dn_thr;
   alt_flags_type           flags;

   assign p3_load  = !p3_valid_ff || out_ready;
   assign in_ready = !p2_valid_ff || p3_load;
   assign p2_move  = p2_valid_ff && p3_load;

   assign p2_valid_in = in_ready ? in_valid : p2_valid_ff;
   assign p3_valid_in = p3_load ? p2_valid_ff : p3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p2_valid_in;
         p3_valid_ff <= p3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         p2_ff <= in_data;
      end
   end

   // altitude thresholds with their hysteresis variants
   always_comb begin
      alt_x = THR_W'(p2_ff.alt);
      gnd_x = THR_W'(cfg.ground);
      trop_x = THR_W'(cfg.trop);
      land_x = THR_W'(cfg.land);
      flags.lt_gnd     = alt_x < gnd_x;
      flags.lt_trop    = alt_x < trop_x;
      flags.lt_trop_lo = alt_x < (trop_x - HYST);
      flags.lt_trop_hi = alt_x < (trop_x + HYST);
      flags.lt_land    = alt_x < land_x;
      flags.lt_land_hi = alt_x < (land_x + HYST);
   end

   // rate times the window span, in cm: GPS above ground level, baro below
   always_comb begin
      rate   = flags.lt_gnd ? CMP_W'(p2_ff.psum) * PA_TO_CM
                            : CMP_W'(p2_ff.asum) * M_TO_CM;
      up_thr = CMP_W'({1'b0, cfg.rise}) * SPAN;
      dn_thr = CMP_W'(cfg.sink) * SPAN;
   end

   always_ff @(posedge clock) begin
      if (p2_move) begin
         p3_op_ff     <= p2_ff.op;
         p3_forced_ff <= p2_ff.forced;
         p3_full_ff   <= p2_ff.full;
         p3_rate_ff   <= rate;
         p3_up_thr_ff <= up_thr;
         p3_dn_thr_ff <= dn_thr;
         p3_flags_ff  <= flags;
      end
   end

   assign out_valid = p3_valid_ff;

   always_comb begin
      out_data.op       = p3_op_ff;
      out_data.forced   = p3_forced_ff;
      out_data.full     = p3_full_ff;
      out_data.rise_hit = p3_rate_ff > p3_up_thr_ff;
      out_data.rise_pos = p3_rate_ff > CMP_ZERO;
      out_data.sink_hit = p3_rate_ff < p3_dn_thr_ff;
      out_data.sink_neg = p3_rate_ff < CMP_ZERO;
      out_data.flags    = p3_flags_ff;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/fpd_phase.sv -----
// Flight phase detector: direction and phase state with hysteresis, and the
// result register that drives the result channel.
// Depends on fpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fpd_phase (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  fpd_pkg::cmp_type             in_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fpd_pkg::PHASE_W-1:0]  rsp_phase,
   output logic [fpd_pkg::DIR_W-1:0]    rsp_direction,
   output logic                         rsp_phase_changed,
   output logic                         rsp_landing_trigger,
   output logic                         rsp_window_full,
   output logic [fpd_pkg::PULSE_W-1:0]  rsp_camera_pulse_ms
);
   import fpd_pkg::*;

   logic               p4_valid_ff, p4_valid_in;
   cmp_type            p4_ff;
   phase_type          phase_ff, phase_in, phase_new;
   dir_type            dir_ff, dir_in, dir_new;
   logic               landing_new;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] rsp_phase_ff, rsp_phase_in;
   logic [DIR_W-1:0]   rsp_dir_ff, rsp_dir_in;
   logic               rsp_changed_ff, rsp_changed_in;
   logic               rsp_landing_ff, rsp_landing_in;
   logic               rsp_full_ff, rsp_full_in;
   logic [PULSE_W-1:0] rsp_pulse_ff, rsp_pulse_in;

   logic               out_load;
   logic               fire;
   logic               rise_go;
   logic               sink_go;
   logic               below_trop;
   logic               below_land;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign in_ready = !p4_valid_ff || out_load;
   assign fire     = p4_valid_ff && out_load;

   assign p4_valid_in  = in_ready ? in_valid : p4_valid_ff;
   assign rsp_valid_in = out_load ? p4_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         p4_ff <= in_data;
      end
   end

   // next state: direction first, then phase from direction and altitude
   always_comb begin
      phase_new   = phase_ff;
      dir_new     = dir_ff;
      landing_new = 1'b0;
      rise_go     = (dir_ff == DIR_UP) ? p4_ff.rise_pos : p4_ff.rise_hit;
      sink_go     = (dir_ff == DIR_DOWN) ? p4_ff.sink_neg : p4_ff.sink_hit;
      below_land  = (phase_ff == PH_LANDING) ? p4_ff.flags.lt_land_hi : p4_ff.flags.lt_land;
      case (phase_ff)
         PH_STRATO_UP: below_trop = p4_ff.flags.lt_trop_lo;
         PH_FALLING:   below_trop = p4_ff.flags.lt_trop_hi;
         default:      below_trop = p4_ff.flags.lt_trop;
      endcase

      if (p4_ff.op.clear) begin
         phase_new = PH_NOFIX;
         dir_new   = DIR_HOVER;
      end else if (p4_ff.op.force_phase) begin
         phase_new = p4_ff.forced;
      end else if (p4_ff.op.sample && p4_ff.full) begin
         if (rise_go) begin
            dir_new = DIR_UP;
         end else if (sink_go) begin
            dir_new = DIR_DOWN;
         end else begin
            dir_new = DIR_HOVER;
         end
         case (dir_new)
            DIR_HOVER: phase_new = p4_ff.flags.lt_gnd ? PH_GROUND : PH_HOVER;
            DIR_UP:    phase_new = below_trop ? PH_TAKEOFF : PH_STRATO_UP;
            default: begin
               if (!below_trop) begin
                  phase_new = PH_STRATO_FALL;
               end else if (below_land) begin
                  phase_new   = PH_LANDING;
                  landing_new = 1'b1;
               end else begin
                  phase_new = PH_FALLING;
               end
            end
         endcase
      end
   end

   always_comb begin
      phase_in = phase_ff;
      dir_in   = dir_ff;
      if (clear) begin
         phase_in = PH_NOFIX;
         dir_in   = DIR_HOVER;
      end else if (fire) begin
         phase_in = phase_new;
         dir_in   = dir_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_NOFIX;
         dir_ff       <= DIR_HOVER;
      end else begin
         p4_valid_ff  <= p4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         dir_ff       <= dir_in;
      end
   end

   // result fields
   always_comb begin
      rsp_phase_in   = rsp_phase_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_landing_in = rsp_landing_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_pulse_in   = rsp_pulse_ff;
      if (fire) begin
         rsp_phase_in   = phase_new;
         rsp_dir_in     = dir_new;
         rsp_changed_in = (phase_new != phase_ff);
         rsp_landing_in = landing_new;
         rsp_full_in    = p4_ff.full;
         rsp_pulse_in   = pulse_ms(phase_new);
      end
   end

   always_ff @(posedge clock) begin
      rsp_phase_ff   <= rsp_phase_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_landing_ff <= rsp_landing_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_pulse_ff   <= rsp_pulse_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_phase           = rsp_phase_ff;
   assign rsp_direction       = rsp_dir_ff;
   assign rsp_phase_changed   = rsp_changed_ff;
   assign rsp_landing_trigger = rsp_landing_ff;
   assign rsp_window_full     = rsp_full_ff;
   assign rsp_camera_pulse_ms = rsp_pulse_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/flight_phase_detector_core.sv -----
// Flight phase detector, top level. Each accepted transaction passes the ring
// read with sum update, rate scaling, compares and the phase update into the
// result register; each stage holds while the stage after it is full.
// Throughput: one transaction per cycle while the result channel is ready;
// the ring memories take one read and one write per cycle.
// Reset (synchronous) clears the pipeline, sums, fill count and phase state and
// loads the default thresholds; the ring memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module flight_phase_detector_core #(
   parameter int WINDOW_LEN = fpd_pkg::WINDOW_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   fpd_req_if.sink                         req_ch,
   fpd_rsp_if.source                       rsp_ch,
   input  logic                            csr_write_en,
   input  logic [fpd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [fpd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fpd_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    test_mode_ff, test_mode_in;
   logic    cfg_clear;
   op_type  req_op;

   logic    win_valid;
   logic    win_ready;
   win_type win_data;
   logic    cmp_valid;
   logic    cmp_ready;
   cmp_type cmp_data;

   always_comb begin
      cfg_in       = cfg_ff;
      test_mode_in = test_mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GROUND:    cfg_in.ground = csr_wdata[GND_W-1:0];
            CSR_TROP:      cfg_in.trop   = csr_wdata[TROP_W-1:0];
            CSR_LANDING:   cfg_in.land   = csr_wdata[LAND_W-1:0];
            CSR_RISE:      cfg_in.rise   = csr_wdata[RISE_W-1:0];
            CSR_SINK:      cfg_in.sink   = csr_wdata[SINK_W-1:0];
            CSR_TEST_MODE: test_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // a threshold write restarts the mission; a test mode write does not
   assign cfg_clear = csr_write_en && (csr_index inside {[CSR_GROUND:CSR_SINK]});

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{ground: GND_RST, trop: TROP_RST, land: LAND_RST,
                           rise: RISE_RST, sink: SINK_RST};
         test_mode_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         test_mode_ff <= test_mode_in;
      end
   end

   // decode the command once; later stages see only the resulting action
   always_comb begin
      req_op = '0;
      case (req_ch.command)
         CMD_SAMPLE: begin
            req_op.sample = !test_mode_ff && req_ch.gps_fix;
            req_op.clear  = !test_mode_ff && !req_ch.gps_fix;
         end
         CMD_RESTART: req_op.clear       = 1'b1;
         CMD_FORCE:   req_op.force_phase = test_mode_ff;
         default: ;
      endcase
   end

   fpd_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .clear     (cfg_clear),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_op     (req_op),
      .in_alt    (req_ch.altitude_m),
      .in_press  (req_ch.pressure_pa),
      .in_forced (phase_type'(req_ch.forced_phase)),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_data  (win_data)
   );

   fpd_rate #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_rate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_data   (win_data),
      .out_valid (cmp_valid),
      .out_ready (cmp_ready),
      .out_data  (cmp_data)
   );

   fpd_phase u_phase (
      .clock               (clock),
      .reset               (reset),
      .clear               (cfg_clear),
      .in_valid            (cmp_valid),
      .in_ready            (cmp_ready),
      .in_data             (cmp_data),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_phase           (rsp_ch.phase),
      .rsp_direction       (rsp_ch.direction),
      .rsp_phase_changed   (rsp_ch.phase_changed),
      .rsp_landing_trigger (rsp_ch.landing_trigger),
      .rsp_window_full     (rsp_ch.window_full),
      .rsp_camera_pulse_ms (rsp_ch.camera_pulse_ms)
   );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking bench for flight_phase_detector_core: a directed table and random
// flight profiles, each result checked against its row or an in-bench phase tracker.
// Depends on fpd_pkg and the fpd_req_if / fpd_rsp_if channel interfaces.
`timescale 1ns / 1ps

module tb;
   import fpd_pkg::*;

   localparam int WIN       = WINDOW_LEN_DEF;
   localparam int SPAN      = WINDOW_LEN_DEF * CHECK_PERIOD_S;
   localparam int CM_PER_M  = 100;
   localparam int CM_PER_PA = -9;
   localparam int ALT_MIN   = -(1 << (ALT_W - 1));
   localparam int ALT_MAX   = (1 << (ALT_W - 1)) - 1;
   localparam int PRESS_MAX = (1 << PRESS_W) - 1;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic                    fix;
      logic signed [ALT_W-1:0] alt;
      logic [PRESS_W-1:0]      press;
      logic [PHASE_W-1:0]      forced;
   } nav_sample_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [DIR_W-1:0]   direction;
      logic               changed;
      logic               landing;
      logic               full;
      logic [PULSE_W-1:0] pulse;
   } phase_report_type;

   typedef struct {
      logic             is_cfg;
      csr_type          reg_idx;
      int               reg_val;
      nav_sample_type   smp;
      logic             known;
      phase_report_type want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fpd_req_if req_ch();
   fpd_rsp_if rsp_ch();

   flight_phase_detector_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   // tracker state and its copy of the limits
   longint             alt_ring [WIN];
   longint             press_ring [WIN];
   longint             fl_asum, fl_psum, fl_last_alt, fl_last_press;
   int                 fl_fill, fl_slot;
   dir_type            fl_dir;
   phase_type          fl_phase;
   logic [GND_W-1:0]   lim_gnd;
   logic [TROP_W-1:0]  lim_trop;
   logic [LAND_W-1:0]  lim_land;
   logic [RISE_W-1:0]  lim_rise;
   logic [SINK_W-1:0]  lim_sink;
   logic               lim_test;

   phase_report_type pending_reports [$];
   int               fault_count   = 0;
   int               items_sent    = 0;
   int               send_idle_pct = 15;
   int               recv_idle_pct = 75;

   function automatic void clear_flight();
      fl_phase = PH_NOFIX;
      fl_dir   = DIR_HOVER;
      fl_asum  = 0;
      fl_psum  = 0;
      fl_fill  = 0;
      fl_slot  = 0;
   endfunction

   function automatic int clip(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic predict_flight_phase(input nav_sample_type s, output phase_report_type r);
      phase_type prior;
      logic      landed;
      longint    a, p, da, dp, rate, up_lim, dn_lim, gnd, trop, land;
      prior  = fl_phase;
      landed = 1'b0;
      a      = longint'(s.alt);
      p      = longint'(s.press);
      gnd    = longint'(lim_gnd);
      case (s.command)
         CMD_SAMPLE: begin
            if (lim_test) begin
               // samples are ignored in test mode
            end else if (!s.fix) begin
               clear_flight();
            end else begin
               if (fl_fill == 0) begin
                  fl_last_alt   = a;
                  fl_last_press = p;
               end
               da            = a - fl_last_alt;
               dp            = p - fl_last_press;
               fl_last_alt   = a;
               fl_last_press = p;
               if (fl_fill >= WIN) begin
                  fl_asum -= alt_ring[fl_slot];
                  fl_psum -= press_ring[fl_slot];
               end else begin
                  fl_fill++;
               end
               alt_ring[fl_slot]   = da;
               press_ring[fl_slot] = dp;
               fl_asum += da;
               fl_psum += dp;
               fl_slot = (fl_slot + 1 >= WIN) ? 0 : fl_slot + 1;
               if (fl_fill >= WIN) begin
                  rate   = (a >= gnd) ? CM_PER_M * fl_asum : CM_PER_PA * fl_psum;
                  up_lim = longint'(lim_rise);
                  dn_lim = longint'($signed(lim_sink));
                  // hysteresis: once moving, the limit in that direction drops to zero
                  if (fl_dir == DIR_UP) up_lim = 0;
                  else if (fl_dir == DIR_DOWN) dn_lim = 0;
                  if (rate > up_lim * SPAN) fl_dir = DIR_UP;
                  else if (rate < dn_lim * SPAN) fl_dir = DIR_DOWN;
                  else fl_dir = DIR_HOVER;
                  trop = longint'(lim_trop);
                  if (fl_phase == PH_STRATO_UP) trop -= ALT_HYSTERESIS;
                  else if (fl_phase == PH_FALLING) trop += ALT_HYSTERESIS;
                  land = longint'(lim_land);
                  if (fl_phase == PH_LANDING) land += ALT_HYSTERESIS;
                  case (fl_dir)
                     DIR_HOVER: begin
                        if (a < gnd) fl_phase = PH_GROUND;
                        else fl_phase = PH_HOVER;
                     end
                     DIR_UP: begin
                        if (a < trop) fl_phase = PH_TAKEOFF;
                        else fl_phase = PH_STRATO_UP;
                     end
                     default: begin
                        if (a >= trop) begin
                           fl_phase = PH_STRATO_FALL;
                        end else if (a < land) begin
                           fl_phase = PH_LANDING;
                           landed   = 1'b1;
                        end else begin
                           fl_phase = PH_FALLING;
                        end
                     end
                  endcase
               end
            end
         end
         CMD_RESTART: clear_flight();
         CMD_FORCE: begin
            if (lim_test) fl_phase = phase_type'(s.forced);
         end
         default: ;
      endcase
      r.phase     = fl_phase;
      r.direction = fl_dir;
      r.changed   = (fl_phase != prior);
      r.landing   = landed;
      r.full      = (fl_fill >= WIN);
      case (fl_phase)
         PH_STRATO_UP:   r.pulse = PULSE_W'(100);
         PH_STRATO_FALL: r.pulse = PULSE_W'(300);
         PH_FALLING:     r.pulse = PULSE_W'(500);
         PH_LANDING:     r.pulse = PULSE_W'(800);
         default:        r.pulse = '0;
      endcase
   endtask

   // drop valid and hold until every outstanding result has come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         CSR_GROUND: begin
            lim_gnd = val[GND_W-1:0];
            clear_flight();
         end
         CSR_TROP: begin
            lim_trop = val[TROP_W-1:0];
            clear_flight();
         end
         CSR_LANDING: begin
            lim_land = val[LAND_W-1:0];
            clear_flight();
         end
         CSR_RISE: begin
            lim_rise = val[RISE_W-1:0];
            clear_flight();
         end
         CSR_SINK: begin
            lim_sink = val[SINK_W-1:0];
            clear_flight();
         end
         CSR_TEST_MODE: lim_test = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_limits(input int gnd, input int trop, input int land, input int rise,
                             input int sink);
      write_csr(CSR_GROUND, CSR_DATA_W'(gnd));
      write_csr(CSR_TROP, CSR_DATA_W'(trop));
      write_csr(CSR_LANDING, CSR_DATA_W'(land));
      write_csr(CSR_RISE, CSR_DATA_W'(rise));
      write_csr(CSR_SINK, CSR_DATA_W'(sink));
   endtask

   task automatic send_sample(input nav_sample_type s, input logic known,
                              input phase_report_type want);
      phase_report_type model;
      csr_write_en <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.command      <= s.command;
      req_ch.gps_fix      <= s.fix;
      req_ch.altitude_m   <= s.alt;
      req_ch.pressure_pa  <= s.press;
      req_ch.forced_phase <= s.forced;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_flight_phase(s, model);
      pending_reports.push_back(known ? want : model);
      items_sent++;
   endtask

   // one flight: restart, then segments of climb, sink and hover with jitter
   task automatic fly(input int n_items);
      nav_sample_type s;
      int             alt, press, climb, left, k;
      case ($urandom_range(3))
         0:       alt = int'(lim_gnd) + int'($urandom_range(1200)) - 600;
         1:       alt = int'(lim_trop) + int'($urandom_range(4000)) - 2000;
         2:       alt = int'(lim_land) + int'($urandom_range(6000)) - 500;
         default: alt = int'($urandom_range(40000)) - 1000;
      endcase
      alt   = clip(alt, ALT_MIN, ALT_MAX);
      press = clip(110000 - alt * 4, 0, PRESS_MAX);
      left  = 0;
      climb = 0;
      k     = 11;
      s         = '0;
      s.command = CMD_RESTART;
      send_sample(s, 1'b0, '0);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(149) == 0) wait_idle();
         if ($urandom_range(99) < 2) begin
            s.command = CMD_W'($urandom_range(3));
            s.fix     = 1'($urandom_range(1));
            s.alt     = ALT_W'($urandom);
            s.press   = PRESS_W'($urandom);
         end else begin
            if (left == 0) begin
               left = $urandom_range(10, 90);
               case ($urandom_range(3))
                  0:       climb = int'($urandom_range(1, 90));
                  1:       climb = -int'($urandom_range(1, 90));
                  2:       climb = int'($urandom_range(6)) - 3;
                  default: climb = int'($urandom_range(30)) - 15;
               endcase
               k = $urandom_range(1, 14);
            end
            left--;
            alt       = clip(alt + climb + int'($urandom_range(4)) - 2, ALT_MIN, ALT_MAX);
            press     = clip(press - climb * k + int'($urandom_range(20)) - 10, 0, PRESS_MAX);
            s.command = CMD_SAMPLE;
            s.fix     = 1'b1;
            s.alt     = ALT_W'(alt);
            s.press   = PRESS_W'(press);
         end
         s.forced = PHASE_W'($urandom_range(7));
         send_sample(s, 1'b0, '0);
      end
   endtask

   function automatic plan_row_type cfg_row(input csr_type idx, input int val);
      plan_row_type r;
      r.is_cfg  = 1'b1;
      r.reg_idx = idx;
      r.reg_val = val;
      r.smp     = '0;
      r.known   = 1'b0;
      r.want    = '0;
      return r;
   endfunction

   function automatic plan_row_type smp_row(input logic [CMD_W-1:0] cmd, input int fix,
                                            input int alt, input int press, input int forced,
                                            input int known, input phase_type ph,
                                            input int chg, input int pulse);
      plan_row_type r;
      r.is_cfg           = 1'b0;
      r.reg_idx          = CSR_GROUND;
      r.reg_val          = 0;
      r.smp.command      = cmd;
      r.smp.fix          = 1'(fix);
      r.smp.alt          = ALT_W'(alt);
      r.smp.press        = PRESS_W'(press);
      r.smp.forced       = PHASE_W'(forced);
      r.known            = 1'(known);
      r.want.phase       = ph;
      r.want.direction   = DIR_HOVER;
      r.want.changed     = 1'(chg);
      r.want.landing     = 1'b0;
      r.want.full        = 1'b0;
      r.want.pulse       = PULSE_W'(pulse);
      return r;
   endfunction

   always @(posedge clock) begin
      phase_report_type got, want;
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.phase     = rsp_ch.phase;
         got.direction = rsp_ch.direction;
         got.changed   = rsp_ch.phase_changed;
         got.landing   = rsp_ch.landing_trigger;
         got.full      = rsp_ch.window_full;
         got.pulse     = rsp_ch.camera_pulse_ms;
         if (pending_reports.size() == 0) begin
            $display("%0t: result with nothing outstanding, phase %0d", $time, got.phase);
            fault_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected ph %0d dir %0d chg %b land %b full %b pulse %0d",
                        $time, want.phase, want.direction, want.changed, want.landing,
                        want.full, want.pulse);
               $display("%0t:              actual ph %0d dir %0d chg %b land %b full %b pulse %0d",
                        $time, got.phase, got.direction, got.changed, got.landing,
                        got.full, got.pulse);
               fault_count++;
            end
         end
      end
   end

   initial begin
      #4_800_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      plan_row_type   plan [$];
      nav_sample_type s;
      int             base;
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.command      = CMD_SAMPLE;
      req_ch.gps_fix      = 1'b0;
      req_ch.altitude_m   = '0;
      req_ch.pressure_pa  = '0;
      req_ch.forced_phase = '0;
      rsp_ch.ready        = 1'b0;
      csr_write_en        = 1'b0;
      csr_index           = CSR_GROUND;
      csr_wdata           = '0;
      lim_gnd             = GND_RST;
      lim_trop            = TROP_RST;
      lim_land            = LAND_RST;
      lim_rise            = RISE_RST;
      lim_sink            = SINK_RST;
      lim_test            = 1'b0;
      fl_last_alt         = 0;
      fl_last_press       = 0;
      clear_flight();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(smp_row(CMD_SAMPLE, 1, 0, 0, 0, 1, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_SAMPLE, 1, ALT_MAX, PRESS_MAX, 7, 1, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_SAMPLE, 1, ALT_MIN, 0, 0, 1, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_UNKNOWN, 1, 500, 90000, 5, 1, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_FORCE, 1, 0, 0, 6, 1, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_SAMPLE, 0, 800, 95000, 0, 1, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_RESTART, 1, 0, 0, 0, 1, PH_NOFIX, 0, 0));
      plan.push_back(cfg_row(CSR_TEST_MODE, 1));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 7, 1, PH_HOVER, 1, 0));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 6, 1, PH_LANDING, 1, 800));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 6, 1, PH_LANDING, 0, 800));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 3, 1, PH_STRATO_UP, 1, 100));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 4, 1, PH_STRATO_FALL, 1, 300));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 5, 1, PH_FALLING, 1, 500));
      plan.push_back(smp_row(CMD_SAMPLE, 1, 5000, 50000, 0, 1, PH_FALLING, 0, 500));
      plan.push_back(smp_row(CMD_SAMPLE, 0, 5000, 50000, 0, 1, PH_FALLING, 0, 500));
      plan.push_back(smp_row(CMD_RESTART, 0, 0, 0, 0, 1, PH_NOFIX, 1, 0));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 2, 1, PH_TAKEOFF, 1, 0));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 1, 1, PH_GROUND, 1, 0));
      plan.push_back(cfg_row(CSR_GROUND, 1500));
      plan.push_back(smp_row(CMD_FORCE, 0, 0, 0, 0, 1, PH_NOFIX, 0, 0));
      plan.push_back(cfg_row(CSR_TEST_MODE, 0));
      plan.push_back(smp_row(CMD_SAMPLE, 1, 1000, 101000, 2, 0, PH_NOFIX, 0, 0));
      plan.push_back(smp_row(CMD_FORCE, 1, 1000, 101000, 7, 1, PH_NOFIX, 0, 0));
      foreach (plan[i]) begin
         if (plan[i].is_cfg) write_csr(plan[i].reg_idx, CSR_DATA_W'(plan[i].reg_val));
         else send_sample(plan[i].smp, plan[i].known, plan[i].want);
      end

      for (int ph = 0; ph < 6; ph++) begin
         send_idle_pct = (ph < 2) ? 15 : (ph < 4) ? 75 : 0;
         recv_idle_pct = (ph < 2) ? 75 : (ph < 4) ? 15 : 0;
         case (ph)
            1: set_limits(10, 9000, 10, 0, 0);
            2: set_limits(9000, 20000, 100000, 2000, -2000);
            3: begin
               set_limits(300, 9500, 5000, 150, -350);
               write_csr(CSR_TEST_MODE, CSR_DATA_W'(1));
               for (int i = 0; i < 30; i++) begin
                  s.command = ($urandom_range(1) == 1) ? CMD_FORCE : CMD_W'($urandom_range(3));
                  s.fix     = 1'($urandom_range(1));
                  s.alt     = ALT_W'($urandom);
                  s.press   = PRESS_W'($urandom);
                  s.forced  = PHASE_W'($urandom_range(7));
                  send_sample(s, 1'b0, '0);
               end
               write_csr(CSR_TEST_MODE, CSR_DATA_W'(0));
            end
            4: set_limits($urandom_range(10, 9000), $urandom_range(9000, 20000),
                          $urandom_range(10, 100000), $urandom_range(2000),
                          -int'($urandom_range(2000)));
            5: set_limits($urandom, $urandom, $urandom, $urandom, $urandom);
            default: ;
         endcase
         base = items_sent;
         while (items_sent - base < 175) fly($urandom_range(60, 160));
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (fault_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule

// ----- flight_phase_detector_core.f -----
hw/rtl/fpd_pkg.sv
hw/rtl/fpd_if.sv
hw/rtl/fpd_window.sv
hw/rtl/fpd_rate.sv
hw/rtl/fpd_phase.sv
hw/rtl/flight_phase_detector_core.sv
verif/tb.sv
